/* rtl/vaps_pkg.sv */
// ----------------------------------------------------------------------------
// vaps_pkg
// Types and fixed constants shared by the voxel path search block.
// ----------------------------------------------------------------------------
package vaps_pkg;

	// grid and cost geometry
	localparam int MAX_DIM   = 16;
	localparam int COORD_W   = 4;
	localparam int DIM_W     = 5;
	localparam int CELL_W    = 12;
	localparam int CELLS     = 4096;
	localparam int CNT_W     = 13;
	localparam int PLANE_W   = 9;
	localparam int FRAC_BITS = 8;
	localparam int LEN_W     = 12;
	localparam int COST_W    = 33;
	localparam int F_W       = 34;
	localparam int SEQ_W     = 12;
	localparam int DIR_W     = 5;
	localparam int DELTA_W   = 5;
	localparam int AXLEN_W   = 16;
	localparam int AXSQ_W    = 32;
	localparam int SUMSQ_W   = 34;
	localparam int RAD_W     = SUMSQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int ITER_W    = 5;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// parent direction codes
	localparam logic [DIR_W-1:0] DIR_NONE = DIR_W'(13);
	localparam logic [DIR_W-1:0] DIR_LAST = DIR_W'(26);

	// command codes
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SIZE_X = 3'd0;
	localparam logic [2:0] REG_SIZE_Y = 3'd1;
	localparam logic [2:0] REG_SIZE_Z = 3'd2;
	localparam logic [2:0] REG_LEN_X  = 3'd3;
	localparam logic [2:0] REG_LEN_Y  = 3'd4;
	localparam logic [2:0] REG_LEN_Z  = 3'd5;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [CELL_W-1:0]  cell_index;
		logic               blocked;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_z;
		logic [COORD_W-1:0] goal_x;
		logic [COORD_W-1:0] goal_y;
		logic [COORD_W-1:0] goal_z;
		logic [CELL_W-1:0]  path_pos;
	} vaps_req_t;

	typedef struct packed {
		logic               found;
		logic [COST_W-1:0]  path_cost;
		logic [CNT_W-1:0]   path_len;
		logic               start_moved;
		logic               goal_moved;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} vaps_rsp_t;

	// per-axis cell offsets for the distance unit
	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic signed [DELTA_W-1:0] dz;
	} dist_vec_t;

	typedef struct packed {
		logic [LEN_W-1:0] x;
		logic [LEN_W-1:0] y;
		logic [LEN_W-1:0] z;
	} axis_len_t;

	typedef enum logic [2:0] {
		D_IDLE, D_MUL, D_SQ, D_ACC, D_ROOT, D_DONE
	} dist_state_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_VCLR, ST_CHK_S, ST_CHK_G, ST_GOAL_FIX,
		ST_H0, ST_H0_W, ST_PUSH_UP, ST_PUSH_CMP, ST_NEXT,
		ST_POP, ST_POP_T, ST_POP_L, ST_SD, ST_SD_A, ST_SD_B, ST_SD_CMP,
		ST_SD_END, ST_POPPED, ST_NB, ST_NB_CHK, ST_NB_STEP, ST_NB_HGO,
		ST_NB_HW, ST_PW_RD, ST_PW_WR, ST_RESP
	} vaps_state_t;

endpackage

/* rtl/vaps_dist.sv */
// ----------------------------------------------------------------------------
// vaps_dist
// Euclidean distance unit: sum of squared axis lengths through two multipliers
// shared by the three axes, then a bit-serial truncated square root in fixed point.
// ----------------------------------------------------------------------------
module vaps_dist import vaps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dist_vec_t         vec,
	input  axis_len_t         lens,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	dist_state_t state_q, state_d;

	logic [COORD_W-1:0] mag_q [3];
	logic [1:0]         axis_q;
	logic [AXLEN_W-1:0] a_q;
	logic [AXSQ_W-1:0]  p_q;
	logic [SUMSQ_W-1:0] acc_q;
	logic [RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [ITER_W-1:0]  iter_q;

	logic [COORD_W-1:0] mag_sel;
	logic [LEN_W-1:0]   len_sel;
	logic [SUMSQ_W-1:0] acc_sum;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic               ge;

	function automatic logic [COORD_W-1:0] mag(input logic signed [DELTA_W-1:0] v);
		logic signed [DELTA_W-1:0] n;
		n = -v;
		return (v < 0) ? COORD_W'(n) : COORD_W'(v);
	endfunction

	// operand select for the current axis
	always_comb begin
		case (axis_q)
			2'd0: begin
				mag_sel = mag_q[0];
				len_sel = lens.x;
			end
			2'd1: begin
				mag_sel = mag_q[1];
				len_sel = lens.y;
			end
			default: begin
				mag_sel = mag_q[2];
				len_sel = lens.z;
			end
		endcase
	end

	assign acc_sum = acc_q + SUMSQ_W'(p_q);

	// one root digit per cycle
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			D_IDLE:  if (start) state_d = D_MUL;
			D_MUL:   state_d = D_SQ;
			D_SQ:    state_d = D_ACC;
			D_ACC:   state_d = (axis_q == 2'd2) ? D_ROOT : D_MUL;
			D_ROOT:  if (iter_q == ITER_W'(ROOT_W - 1)) state_d = D_DONE;
			D_DONE:  state_d = D_IDLE;
			default: state_d = D_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == D_DONE);
		root = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					mag_q[0] <= mag(vec.dx);
					mag_q[1] <= mag(vec.dy);
					mag_q[2] <= mag(vec.dz);
					axis_q   <= 2'd0;
					acc_q    <= '0;
				end
			end
			D_MUL: a_q <= AXLEN_W'(mag_sel * len_sel);
			D_SQ:  p_q <= AXSQ_W'(a_q * a_q);
			D_ACC: begin
				acc_q  <= acc_sum;
				axis_q <= axis_q + 2'd1;
				if (axis_q == 2'd2) begin
					rad_q  <= {acc_sum, (2 * FRAC_BITS)'(0)};
					rem_q  <= '0;
					root_q <= '0;
					iter_q <= '0;
				end
			end
			D_ROOT: begin
				rem_q  <= ge ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], ge};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				iter_q <= iter_q + ITER_W'(1);
			end
			default: ;
		endcase
	end

endmodule

/* rtl/voxel_astar_path_search.sv */
// ----------------------------------------------------------------------------
// voxel_astar_path_search
// A* search over a 3-D occupancy grid with 26-neighbour moves, binary heap
// open list in memory, shared distance unit, path read-back end-first.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  cmd       in         cmd_valid / cmd_stall     vaps_req_t
//  res       out        res_valid / res_stall     vaps_rsp_t
//  apb       in         psel penable pwrite       paddr, pwdata, prdata
//
//  after reset a pass over all 4096 cells clears occupancy; no item is taken meanwhile
//  occupancy write and path read go from idle straight to the result register
//  a search starts with a visited sweep over all 4096 cells, then per popped cell
//  runs the distance unit twice for each pushed neighbour plus heap steps per
//  tree level; the distance unit sets the pace
//  one item at a time; the result register holds a result while res_stall
// ----------------------------------------------------------------------------
module voxel_astar_path_search import vaps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  vaps_req_t         cmd_item,
	output logic              res_valid,
	input  logic              res_stall,
	output vaps_rsp_t         res_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef struct packed {
		logic [F_W-1:0]     f;
		logic [COST_W-1:0]  g;
		logic [SEQ_W-1:0]   seq;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} heap_ent_t;

	typedef struct packed {
		logic [1:0] cx;
		logic [1:0] cy;
		logic [1:0] cz;
	} dir_off_t;

	vaps_state_t state_q, state_d;

	// configuration
	logic [DIM_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [LEN_W-1:0] len_x_q, len_y_q, len_z_q;

	// search context
	logic [DIM_W-1:0]   nx_q, ny_q, nz_q;
	logic [PLANE_W-1:0] plane_q;
	logic [COORD_W-1:0] sx_q, sy_q, sz_q, gx_q, gy_q, gz_q;
	logic [COORD_W-1:0] nbx_q, nby_q, nbz_q, px_q, py_q, pz_q;
	logic [CELL_W-1:0]  clr_q;
	logic [CNT_W-1:0]   heap_cnt_q, hi_q, csel_q, pn_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [DIR_W-1:0]   dir_q;
	logic [COST_W-1:0]  gnew_q;
	heap_ent_t          ent_q, top_q, last_q, child_q;

	// last result
	logic               found_q, smoved_q, gmoved_q;
	logic [COST_W-1:0]  cost_q;
	logic [CNT_W-1:0]   len_q;
	logic               cell_sel_q;
	vaps_rsp_t          res_q;
	logic               res_valid_q;

	// memories and their read registers
	logic                     occ_mem  [CELLS];
	logic                     vis_mem  [CELLS];
	logic [DIR_W-1:0]         par_mem  [CELLS];
	heap_ent_t                heap_mem [CELLS];
	logic [3*COORD_W-1:0]     path_mem [CELLS];
	logic                     occ_rd_q, vis_rd_q;
	logic [DIR_W-1:0]         par_rd_q;
	heap_ent_t                heap_rd_q;
	logic [3*COORD_W-1:0]     path_rd_q;

	// memory controls
	logic              occ_we, occ_wd, vis_we, vis_wd, par_we, heap_we, path_we, path_re;
	logic [CELL_W-1:0] occ_wa, vis_wa, heap_wa, heap_ra;
	heap_ent_t         heap_wd;

	// distance unit
	logic              dist_start, dist_done;
	dist_vec_t         dist_vec;
	axis_len_t         lens;
	logic [ROOT_W-1:0] dist_root;

	// combinational helpers
	logic               accept, out_load, cfg_we;
	logic [DIM_W-1:0]   ex, ey, ez;
	logic [COORD_W-1:0] ax, ay, az;
	logic [CELL_W-1:0]  cell_addr;
	dir_off_t           off, poff;
	logic [DIM_W:0]     sumx, sumy, sumz;
	logic               nb_ok;
	logic [COORD_W-1:0] nbx, nby, nbz;
	logic [CNT_W-1:0]   cidx, pidx;
	logic               pw_stop;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		if (v == '0) return DIM_W'(1);
		if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [COORD_W-1:0] clampc(input logic [COORD_W-1:0] c,
	                                              input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] m;
		m = n - DIM_W'(1);
		return (DIM_W'(c) > m) ? COORD_W'(m) : c;
	endfunction

	function automatic logic key_less(input heap_ent_t a, input heap_ent_t b);
		return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
	endfunction

	// direction code to per-axis offsets plus one
	function automatic dir_off_t dir_off(input logic [DIR_W-1:0] d);
		dir_off_t         o;
		logic [DIR_W-1:0] r;
		o.cx = (d >= DIR_W'(18)) ? 2'd2 : (d >= DIR_W'(9)) ? 2'd1 : 2'd0;
		r    = d - DIR_W'(9) * DIR_W'(o.cx);
		o.cy = (r >= DIR_W'(6)) ? 2'd2 : (r >= DIR_W'(3)) ? 2'd1 : 2'd0;
		o.cz = 2'(r - DIR_W'(3) * DIR_W'(o.cy));
		return o;
	endfunction

	function automatic logic signed [DELTA_W-1:0] dsub(input logic [COORD_W-1:0] a,
	                                                    input logic [COORD_W-1:0] b);
		return DELTA_W'(a) - DELTA_W'(b);
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= DIM_W'(16);
			size_y_q <= DIM_W'(16);
			size_z_q <= DIM_W'(16);
			len_x_q  <= LEN_W'(100);
			len_y_q  <= LEN_W'(100);
			len_z_q  <= LEN_W'(100);
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_SIZE_X: size_x_q <= pwdata[DIM_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[DIM_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[DIM_W-1:0];
				REG_LEN_X:  len_x_q  <= pwdata[LEN_W-1:0];
				REG_LEN_Y:  len_y_q  <= pwdata[LEN_W-1:0];
				REG_LEN_Z:  len_z_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SIZE_X: prdata = DATA_W'(size_x_q);
			REG_SIZE_Y: prdata = DATA_W'(size_y_q);
			REG_SIZE_Z: prdata = DATA_W'(size_z_q);
			REG_LEN_X:  prdata = DATA_W'(len_x_q);
			REG_LEN_Y:  prdata = DATA_W'(len_y_q);
			REG_LEN_Z:  prdata = DATA_W'(len_z_q);
			default:    prdata = '0;
		endcase
	end

	assign lens = '{x: len_x_q, y: len_y_q, z: len_z_q};

	// handshakes
	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_load  = (state_q == ST_RESP) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign ex = eff_dim(size_x_q);
	assign ey = eff_dim(size_y_q);
	assign ez = eff_dim(size_z_q);

	// neighbour of the popped cell for the current direction
	assign off  = dir_off(dir_q);
	assign sumx = (DIM_W+1)'(top_q.x) + (DIM_W+1)'(off.cx);
	assign sumy = (DIM_W+1)'(top_q.y) + (DIM_W+1)'(off.cy);
	assign sumz = (DIM_W+1)'(top_q.z) + (DIM_W+1)'(off.cz);
	assign nbx  = COORD_W'(sumx - (DIM_W+1)'(1));
	assign nby  = COORD_W'(sumy - (DIM_W+1)'(1));
	assign nbz  = COORD_W'(sumz - (DIM_W+1)'(1));
	assign nb_ok = (sumx != '0) && (sumx - (DIM_W+1)'(1) < (DIM_W+1)'(nx_q))
	            && (sumy != '0) && (sumy - (DIM_W+1)'(1) < (DIM_W+1)'(ny_q))
	            && (sumz != '0) && (sumz - (DIM_W+1)'(1) < (DIM_W+1)'(nz_q));

	// path walk step
	assign poff    = dir_off(par_rd_q);
	assign pw_stop = (par_rd_q == DIR_NONE) || (par_rd_q > DIR_LAST)
	              || (pn_q == CNT_W'(CELLS - 1));

	// heap child and parent positions
	assign cidx = CNT_W'({hi_q, 1'b1});
	assign pidx = (hi_q - CNT_W'(1)) >> 1;

	// cell address for the probe, marking and path walk ports
	always_comb begin
		case (state_q)
			ST_CHK_S, ST_H0: begin
				ax = sx_q;
				ay = sy_q;
				az = sz_q;
			end
			ST_CHK_G: begin
				ax = gx_q;
				ay = gy_q;
				az = gz_q;
			end
			ST_NB: begin
				ax = nbx;
				ay = nby;
				az = nbz;
			end
			ST_NB_CHK: begin
				ax = nbx_q;
				ay = nby_q;
				az = nbz_q;
			end
			default: begin
				ax = px_q;
				ay = py_q;
				az = pz_q;
			end
		endcase
		cell_addr = CELL_W'(CNT_W'(ax) * CNT_W'(plane_q) + CNT_W'(ay) * CNT_W'(nz_q)
		                    + CNT_W'(az));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd_item.cmd == CMD_SEARCH) ? ST_VCLR : ST_RESP;
				end
			end
			ST_VCLR:     if (clr_q == '1) state_d = ST_CHK_S;
			ST_CHK_S:    state_d = ST_CHK_G;
			ST_CHK_G:    state_d = ST_GOAL_FIX;
			ST_GOAL_FIX: state_d = ST_H0;
			ST_H0:       state_d = ST_H0_W;
			ST_H0_W:     if (dist_done) state_d = ST_PUSH_UP;
			ST_PUSH_UP:  state_d = (hi_q == '0) ? ST_NEXT : ST_PUSH_CMP;
			ST_PUSH_CMP: state_d = key_less(ent_q, heap_rd_q) ? ST_PUSH_UP : ST_NEXT;
			ST_NEXT: begin
				if (dir_q == DIR_LAST) begin
					state_d = (heap_cnt_q != '0) ? ST_POP : ST_RESP;
				end else begin
					state_d = ST_NB;
				end
			end
			ST_POP:   state_d = ST_POP_T;
			ST_POP_T: state_d = ST_POP_L;
			ST_POP_L: state_d = ST_SD;
			ST_SD:    state_d = (cidx >= heap_cnt_q) ? ST_SD_END : ST_SD_A;
			ST_SD_A:  state_d = (cidx + CNT_W'(1) < heap_cnt_q) ? ST_SD_B : ST_SD_CMP;
			ST_SD_B:  state_d = ST_SD_CMP;
			ST_SD_CMP: state_d = key_less(child_q, last_q) ? ST_SD : ST_SD_END;
			ST_SD_END: state_d = ST_POPPED;
			ST_POPPED: begin
				if (top_q.x == gx_q && top_q.y == gy_q && top_q.z == gz_q) begin
					state_d = ST_PW_RD;
				end else begin
					state_d = ST_NB;
				end
			end
			ST_NB:      state_d = nb_ok ? ST_NB_CHK : ST_NEXT;
			ST_NB_CHK:  state_d = (vis_rd_q || occ_rd_q) ? ST_NEXT : ST_NB_STEP;
			ST_NB_STEP: if (dist_done) state_d = ST_NB_HGO;
			ST_NB_HGO:  state_d = ST_NB_HW;
			ST_NB_HW:   if (dist_done) state_d = ST_PUSH_UP;
			ST_PW_RD:   state_d = ST_PW_WR;
			ST_PW_WR:   state_d = pw_stop ? ST_RESP : ST_PW_RD;
			ST_RESP:    if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory and distance unit controls
	always_comb begin
		occ_we     = 1'b0;
		occ_wa     = clr_q;
		occ_wd     = 1'b0;
		vis_we     = 1'b0;
		vis_wa     = cell_addr;
		vis_wd     = 1'b1;
		par_we     = 1'b0;
		heap_we    = 1'b0;
		heap_wa    = hi_q[CELL_W-1:0];
		heap_wd    = ent_q;
		heap_ra    = '0;
		path_we    = 1'b0;
		path_re    = 1'b0;
		dist_start = 1'b0;
		dist_vec   = '{dx: dsub(nbx_q, gx_q), dy: dsub(nby_q, gy_q), dz: dsub(nbz_q, gz_q)};
		case (state_q)
			ST_CLEAR: occ_we = 1'b1;
			ST_IDLE: begin
				if (accept && cmd_item.cmd == CMD_WRITE) begin
					occ_we = 1'b1;
					occ_wa = cmd_item.cell_index;
					occ_wd = cmd_item.blocked;
				end
				path_re = accept && (cmd_item.cmd == CMD_READ);
			end
			ST_VCLR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				vis_wd = 1'b0;
			end
			ST_H0: begin
				vis_we     = 1'b1;
				par_we     = 1'b1;
				dist_start = 1'b1;
				dist_vec   = '{dx: dsub(sx_q, gx_q), dy: dsub(sy_q, gy_q),
				               dz: dsub(sz_q, gz_q)};
			end
			ST_PUSH_UP: begin
				heap_we = (hi_q == '0);
				heap_ra = pidx[CELL_W-1:0];
			end
			ST_PUSH_CMP: begin
				heap_we = 1'b1;
				heap_wd = key_less(ent_q, heap_rd_q) ? heap_rd_q : ent_q;
			end
			ST_POP_T: heap_ra = CELL_W'(heap_cnt_q - CNT_W'(1));
			ST_SD:    heap_ra = cidx[CELL_W-1:0];
			ST_SD_A:  heap_ra = CELL_W'(cidx + CNT_W'(1));
			ST_SD_CMP: begin
				heap_we = key_less(child_q, last_q);
				heap_wd = child_q;
			end
			ST_SD_END: begin
				heap_we = (heap_cnt_q != '0);
				heap_wd = last_q;
			end
			ST_NB_CHK: begin
				if (!vis_rd_q && !occ_rd_q) begin
					vis_we     = 1'b1;
					par_we     = 1'b1;
					dist_start = 1'b1;
				end
				dist_vec = '{dx: DELTA_W'(off.cx) - DELTA_W'(1),
				             dy: DELTA_W'(off.cy) - DELTA_W'(1),
				             dz: DELTA_W'(off.cz) - DELTA_W'(1)};
			end
			ST_NB_HGO: dist_start = 1'b1;
			ST_PW_WR:  path_we = 1'b1;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (occ_we) occ_mem[occ_wa] <= occ_wd;
		occ_rd_q <= occ_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[cell_addr] <= (state_q == ST_H0) ? DIR_NONE : dir_q;
		par_rd_q <= par_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		heap_rd_q <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (path_we) path_mem[pn_q[CELL_W-1:0]] <= {px_q, py_q, pz_q};
		if (path_re) path_rd_q <= path_mem[cmd_item.path_pos];
	end

	vaps_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.vec    (dist_vec),
		.lens   (lens),
		.done   (dist_done),
		.root   (dist_root)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			cost_q      <= '0;
			len_q       <= '0;
			smoved_q    <= 1'b0;
			gmoved_q    <= 1'b0;
			heap_cnt_q  <= '0;
			seq_q       <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= out_load || (res_valid_q && res_stall);
			case (state_q)
				ST_CLEAR, ST_VCLR: clr_q <= clr_q + CELL_W'(1);
				ST_IDLE: begin
					clr_q <= '0;
					if (accept && cmd_item.cmd == CMD_SEARCH) begin
						found_q  <= 1'b0;
						cost_q   <= '0;
						len_q    <= '0;
						smoved_q <= 1'b0;
						gmoved_q <= 1'b0;
					end
				end
				ST_CHK_G: if (occ_rd_q) smoved_q <= 1'b1;
				ST_GOAL_FIX: if (occ_rd_q) gmoved_q <= 1'b1;
				ST_H0: begin
					heap_cnt_q <= '0;
					seq_q      <= '0;
				end
				ST_H0_W, ST_NB_HW: begin
					if (dist_done) begin
						heap_cnt_q <= heap_cnt_q + CNT_W'(1);
						seq_q      <= seq_q + SEQ_W'(1);
					end
				end
				ST_POP_T: heap_cnt_q <= heap_cnt_q - CNT_W'(1);
				ST_POPPED: begin
					if (top_q.x == gx_q && top_q.y == gy_q && top_q.z == gz_q) begin
						found_q <= 1'b1;
						cost_q  <= top_q.g;
					end
				end
				ST_PW_WR: if (pw_stop) len_q <= pn_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cell_sel_q <= (cmd_item.cmd == CMD_READ)
					           && (CNT_W'(cmd_item.path_pos) < len_q);
					nx_q    <= ex;
					ny_q    <= ey;
					nz_q    <= ez;
					plane_q <= PLANE_W'(ey * ez);
					sx_q    <= clampc(cmd_item.start_x, ex);
					sy_q    <= clampc(cmd_item.start_y, ey);
					sz_q    <= clampc(cmd_item.start_z, ez);
					gx_q    <= clampc(cmd_item.goal_x, ex);
					gy_q    <= clampc(cmd_item.goal_y, ey);
					gz_q    <= clampc(cmd_item.goal_z, ez);
				end
			end
			ST_CHK_G: begin
				if (occ_rd_q) begin
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
				end
			end
			ST_GOAL_FIX: begin
				if (occ_rd_q) begin
					gx_q <= COORD_W'(nx_q - DIM_W'(1));
					gy_q <= COORD_W'(ny_q - DIM_W'(1));
					gz_q <= COORD_W'(nz_q - DIM_W'(1));
				end
			end
			ST_H0: dir_q <= DIR_LAST;
			ST_H0_W: begin
				ent_q <= '{f: F_W'(dist_root), g: '0, seq: '0, x: sx_q, y: sy_q, z: sz_q};
				hi_q  <= '0;
			end
			ST_PUSH_CMP: if (key_less(ent_q, heap_rd_q)) hi_q <= pidx;
			ST_NEXT: if (dir_q != DIR_LAST) dir_q <= dir_q + DIR_W'(1);
			ST_POP_T: top_q <= heap_rd_q;
			ST_POP_L: begin
				last_q <= heap_rd_q;
				hi_q   <= '0;
			end
			ST_SD_A: begin
				child_q <= heap_rd_q;
				csel_q  <= cidx;
			end
			ST_SD_B: begin
				if (key_less(heap_rd_q, child_q)) begin
					child_q <= heap_rd_q;
					csel_q  <= cidx + CNT_W'(1);
				end
			end
			ST_SD_CMP: if (key_less(child_q, last_q)) hi_q <= csel_q;
			ST_POPPED: begin
				dir_q <= '0;
				px_q  <= top_q.x;
				py_q  <= top_q.y;
				pz_q  <= top_q.z;
				pn_q  <= '0;
			end
			ST_NB: begin
				nbx_q <= nbx;
				nby_q <= nby;
				nbz_q <= nbz;
			end
			ST_NB_STEP: if (dist_done) gnew_q <= top_q.g + COST_W'(dist_root);
			ST_NB_HW: begin
				ent_q <= '{f: F_W'(gnew_q) + F_W'(dist_root), g: gnew_q, seq: seq_q,
				           x: nbx_q, y: nby_q, z: nbz_q};
				hi_q  <= heap_cnt_q;
			end
			ST_PW_WR: begin
				pn_q <= pn_q + CNT_W'(1);
				px_q <= COORD_W'(DIM_W'(px_q) + DIM_W'(1) - DIM_W'(poff.cx));
				py_q <= COORD_W'(DIM_W'(py_q) + DIM_W'(1) - DIM_W'(poff.cy));
				pz_q <= COORD_W'(DIM_W'(pz_q) + DIM_W'(1) - DIM_W'(poff.cz));
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.found       <= found_q;
			res_q.path_cost   <= cost_q;
			res_q.path_len    <= len_q;
			res_q.start_moved <= smoved_q;
			res_q.goal_moved  <= gmoved_q;
			res_q.cell_x      <= cell_sel_q ? path_rd_q[3*COORD_W-1 -: COORD_W] : '0;
			res_q.cell_y      <= cell_sel_q ? path_rd_q[2*COORD_W-1 -: COORD_W] : '0;
			res_q.cell_z      <= cell_sel_q ? path_rd_q[COORD_W-1:0] : '0;
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the voxel path search block against its own A* predictor: occupancy
// writes, searches and path reads under several grid and length settings,
// with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import vaps_pkg::*;

	localparam int GRID_CELLS = 4096;
	localparam longint unsigned COST_SAT = 64'h1_FFFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	vaps_req_t         cmd_item = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	vaps_rsp_t         res_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	voxel_astar_path_search uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [4:0]        reg_size [6];
	int unsigned       grid_n [3];
	int unsigned       axis_len [3];
	bit                occ [GRID_CELLS];
	bit                seen [GRID_CELLS];
	logic [DIR_W-1:0]  came_from [GRID_CELLS];
	longint unsigned   open_f [GRID_CELLS];
	longint unsigned   open_g [GRID_CELLS];
	int unsigned       open_seq [GRID_CELLS];
	int unsigned       open_cell [GRID_CELLS];
	int unsigned       open_cnt;
	int unsigned       seq_ctr;
	logic [11:0]       route [GRID_CELLS][3];
	vaps_rsp_t         last_search;

	vaps_req_t         pending_items [$];
	vaps_rsp_t         expected_rsp [$];
	int                mismatches = 0;
	bit                idling_on = 1'b1;
	int                send_gap = 0;
	int                stall_left = 0;

	function automatic int unsigned clamp_dim(input logic [4:0] v);
		if (v < 1) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned step_len(input int dx, input int dy, input int dz);
		longint unsigned ax, ay, az;
		ax = longint'(dx < 0 ? -dx : dx) * axis_len[0];
		ay = longint'(dy < 0 ? -dy : dy) * axis_len[1];
		az = longint'(dz < 0 ? -dz : dz) * axis_len[2];
		return int_sqrt((ax * ax + ay * ay + az * az) << (2 * FRAC_BITS));
	endfunction

	function automatic bit key_lt(input longint unsigned fa, input int unsigned sa,
			input longint unsigned fb, input int unsigned sb);
		return fa < fb || (fa == fb && sa < sb);
	endfunction

	function automatic void open_push(input longint unsigned f, input longint unsigned g,
			input int unsigned node);
		int unsigned i, p;
		if (open_cnt >= GRID_CELLS) return;
		i = open_cnt++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!key_lt(f, seq_ctr, open_f[p], open_seq[p])) break;
			open_f[i] = open_f[p]; open_g[i] = open_g[p];
			open_seq[i] = open_seq[p]; open_cell[i] = open_cell[p];
			i = p;
		end
		open_f[i] = f; open_g[i] = g; open_seq[i] = seq_ctr; open_cell[i] = node;
		seq_ctr++;
	endfunction

	// removes the root; its g and cell come back through the outputs
	function automatic void open_pop(output longint unsigned g, output int unsigned node);
		longint unsigned lf, lg;
		int unsigned ls, lc, i, c;
		g = open_g[0];
		node = open_cell[0];
		open_cnt--;
		lf = open_f[open_cnt]; lg = open_g[open_cnt];
		ls = open_seq[open_cnt]; lc = open_cell[open_cnt];
		i = 0;
		forever begin
			c = 2 * i + 1;
			if (c >= open_cnt) break;
			if (c + 1 < open_cnt && key_lt(open_f[c+1], open_seq[c+1], open_f[c], open_seq[c]))
				c++;
			if (!key_lt(open_f[c], open_seq[c], lf, ls)) break;
			open_f[i] = open_f[c]; open_g[i] = open_g[c];
			open_seq[i] = open_seq[c]; open_cell[i] = open_cell[c];
			i = c;
		end
		if (open_cnt > 0) begin
			open_f[i] = lf; open_g[i] = lg; open_seq[i] = ls; open_cell[i] = lc;
		end
	endfunction

	function automatic void astar(input vaps_req_t r);
		int unsigned nx, ny, nz, plane, sidx, eidx, node, n, d;
		int sx, sy, sz, ex, ey, ez, cx, cy, cz, px, py, pz, dx, dy, dz, idx;
		longint unsigned g, ng;
		nx = grid_n[0]; ny = grid_n[1]; nz = grid_n[2];
		plane = ny * nz;
		sx = r.start_x > nx - 1 ? nx - 1 : r.start_x;
		sy = r.start_y > ny - 1 ? ny - 1 : r.start_y;
		sz = r.start_z > nz - 1 ? nz - 1 : r.start_z;
		ex = r.goal_x > nx - 1 ? nx - 1 : r.goal_x;
		ey = r.goal_y > ny - 1 ? ny - 1 : r.goal_y;
		ez = r.goal_z > nz - 1 ? nz - 1 : r.goal_z;
		last_search = '0;
		if (occ[sx * plane + sy * nz + sz]) begin
			sx = 0; sy = 0; sz = 0;
			last_search.start_moved = 1'b1;
		end
		if (occ[ex * plane + ey * nz + ez]) begin
			ex = nx - 1; ey = ny - 1; ez = nz - 1;
			last_search.goal_moved = 1'b1;
		end
		sidx = sx * plane + sy * nz + sz;
		eidx = ex * plane + ey * nz + ez;
		foreach (seen[k]) seen[k] = 1'b0;
		open_cnt = 0;
		seq_ctr = 0;
		seen[sidx] = 1'b1;
		came_from[sidx] = DIR_NONE;
		open_push(step_len(sx - ex, sy - ey, sz - ez), 0, sidx);
		while (open_cnt > 0) begin
			open_pop(g, node);
			cx = node / plane; cy = (node / nz) % ny; cz = node % nz;
			if (node == eidx) begin
				last_search.found = 1'b1;
				last_search.path_cost = g > COST_SAT ? COST_SAT : g;
				n = 0;
				// walk parents back toward the start
				while (n < GRID_CELLS) begin
					d = came_from[cx * plane + cy * nz + cz];
					route[n][0] = cx; route[n][1] = cy; route[n][2] = cz;
					n++;
					if (d == DIR_NONE || d > DIR_LAST) break;
					cx = cx + 1 - d / 9;
					cy = cy + 1 - (d / 3) % 3;
					cz = cz + 1 - d % 3;
				end
				last_search.path_len = n;
				break;
			end
			for (dx = -1; dx <= 1; dx++)
				for (dy = -1; dy <= 1; dy++)
					for (dz = -1; dz <= 1; dz++) begin
						px = cx + dx; py = cy + dy; pz = cz + dz;
						if (px < 0 || px >= nx || py < 0 || py >= ny || pz < 0 || pz >= nz)
							continue;
						idx = px * plane + py * nz + pz;
						if (seen[idx] || occ[idx]) continue;
						seen[idx] = 1'b1;
						came_from[idx] = (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
						ng = g + step_len(dx, dy, dz);
						open_push(ng + step_len(px - ex, py - ey, pz - ez), ng, idx);
					end
		end
	endfunction

	function automatic vaps_rsp_t predict_rsp(input vaps_req_t r);
		vaps_rsp_t o;
		if (r.cmd == CMD_WRITE) occ[r.cell_index] = r.blocked;
		else if (r.cmd == CMD_SEARCH) astar(r);
		o = last_search;
		o.cell_x = '0; o.cell_y = '0; o.cell_z = '0;
		if (r.cmd == CMD_READ && r.path_pos < last_search.path_len) begin
			o.cell_x = route[r.path_pos][0];
			o.cell_y = route[r.path_pos][1];
			o.cell_z = route[r.path_pos][2];
		end
		return o;
	endfunction

	// item driver with random idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_rsp.push_back(predict_rsp(cmd_item));
			if (cmd_valid && cmd_stall) begin
				// hold the stalled item
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				cmd_valid <= 1'b0;
			end else if (idling_on && pending_items.size() > 0 && $urandom_range(0, 3) == 0) begin
				send_gap <= $urandom_range(1, 8) - 1;
				cmd_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cmd_item <= pending_items.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result monitor with random stall bursts
	always @(posedge clk) begin
		vaps_rsp_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item %p", res_item);
				end else begin
					want = expected_rsp.pop_front();
					if (res_item.found !== want.found || res_item.path_cost !== want.path_cost ||
							res_item.path_len !== want.path_len ||
							res_item.start_moved !== want.start_moved ||
							res_item.goal_moved !== want.goal_moved ||
							res_item.cell_x !== want.cell_x || res_item.cell_y !== want.cell_y ||
							res_item.cell_z !== want.cell_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result differs: expected %p actual %p", want, res_item);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(1, 8) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx <= REG_SIZE_Z) begin
			reg_size[idx] = val[4:0];
			grid_n[idx] = clamp_dim(val[4:0]);
		end else begin
			axis_len[idx - REG_LEN_X] = val[LEN_W-1:0];
		end
	endtask

	task automatic set_grid(input int sx, input int sy, input int sz,
			input int lx, input int ly, input int lz);
		apb_write(REG_SIZE_X, sx); apb_write(REG_SIZE_Y, sy); apb_write(REG_SIZE_Z, sz);
		apb_write(REG_LEN_X, lx); apb_write(REG_LEN_Y, ly); apb_write(REG_LEN_Z, lz);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || cmd_valid || expected_rsp.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic vaps_req_t noise_item(input logic [1:0] c);
		vaps_req_t r;
		r = $bits(vaps_req_t)'({$urandom, $urandom});
		r.cmd = c;
		return r;
	endfunction

	function automatic void add_write(input int idx, input bit b);
		vaps_req_t r;
		r = noise_item(CMD_WRITE);
		r.cell_index = idx; r.blocked = b;
		pending_items.push_back(r);
	endfunction

	function automatic void add_search(input int sx, input int sy, input int sz,
			input int gx, input int gy, input int gz);
		vaps_req_t r;
		r = noise_item(CMD_SEARCH);
		r.start_x = sx; r.start_y = sy; r.start_z = sz;
		r.goal_x = gx; r.goal_y = gy; r.goal_z = gz;
		pending_items.push_back(r);
	endfunction

	function automatic void add_read(input int pos);
		vaps_req_t r;
		r = noise_item(CMD_READ);
		r.path_pos = pos;
		pending_items.push_back(r);
	endfunction

	// random mix: half writes, mostly inside the grid, then searches, reads and an unused command
	function automatic void add_random(input int count);
		int cells, pick;
		vaps_req_t r;
		cells = grid_n[0] * grid_n[1] * grid_n[2];
		repeat (count) begin
			pick = $urandom_range(0, 19);
			if (pick < 10) begin
				r = noise_item(CMD_WRITE);
				if ($urandom_range(0, 9) < 7) r.cell_index = $urandom_range(0, cells - 1);
				r.blocked = $urandom_range(0, 9) < 3;
			end else if (pick < 15) begin
				r = noise_item(CMD_SEARCH);
				if ($urandom_range(0, 3) != 0) begin
					r.start_x = $urandom_range(0, grid_n[0] - 1);
					r.start_y = $urandom_range(0, grid_n[1] - 1);
					r.start_z = $urandom_range(0, grid_n[2] - 1);
					r.goal_x = $urandom_range(0, grid_n[0] - 1);
					r.goal_y = $urandom_range(0, grid_n[1] - 1);
					r.goal_z = $urandom_range(0, grid_n[2] - 1);
				end
			end else if (pick < 19) begin
				r = noise_item(CMD_READ);
				if ($urandom_range(0, 4) != 0) r.path_pos = $urandom_range(0, 9);
			end else begin
				r = noise_item(2'd3);
			end
			pending_items.push_back(r);
		end
	endfunction

	initial begin
		for (int i = 0; i < 3; i++) begin
			grid_n[i] = MAX_DIM;
			axis_len[i] = 100;
		end
		foreach (occ[k]) occ[k] = 1'b0;
		last_search = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// default grid: reads before any search, unused command, short searches
		add_read(0);
		pending_items.push_back(noise_item(2'd3));
		add_write(4095, 1'b1);
		add_write(4095, 1'b0);
		add_search(0, 0, 0, 2, 3, 1);
		add_read(0);
		add_read(3);
		add_read(4095);
		add_write(9 * 256 + 9 * 16 + 9, 1'b1);
		add_search(9, 9, 9, 1, 1, 1);
		add_read(1);
		add_search(5, 5, 5, 5, 5, 5);
		add_read(0);
		wait_drained();

		// line grid with oversized x: no path, blocked end, zero length axis
		set_grid(31, 1, 1, 4095, 0, 1);
		add_write(5, 1'b1);
		add_search(0, 15, 15, 9, 0, 0);
		add_write(12, 1'b1);
		add_search(8, 0, 0, 12, 0, 0);
		add_read(7);
		add_search(15, 0, 0, 6, 0, 0);
		add_read(9);
		add_random(12);
		wait_drained();

		// sizes of zero clamp to a single cell
		set_grid(0, 0, 0, 1, 4095, 4095);
		add_search(15, 15, 15, 0, 0, 0);
		add_read(0);
		add_read(1);
		wait_drained();

		set_grid(4, 4, 4, 4095, 4095, 4095);
		add_random(35);
		wait_drained();

		set_grid(3, 5, 2, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095));
		add_random(20);
		wait_drained();

		// closing stretch without idling
		idling_on = 1'b0;
		set_grid(5, 3, 3, $urandom_range(1, 4095), $urandom_range(1, 4095),
			$urandom_range(1, 4095));
		add_random(20);
		wait_drained();

		if (mismatches == 0)
			$display("voxel_astar_path_search: match");
		else
			$display("voxel_astar_path_search: mismatch");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("voxel_astar_path_search: mismatch");
		$finish;
	end

endmodule
